// ===== src/dtfu_pkg.sv =====
// shared types, constants and helpers of the depth test fragment unit
package dtfu_pkg;

  localparam int unsigned COORD_W        = 16;
  localparam int unsigned FRAC_W         = 4;
  localparam int unsigned PX_W           = COORD_W - FRAC_W - 1;
  localparam int unsigned DIM_W          = 13;
  localparam int unsigned CFG_W          = 10;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned DEPTH_W        = 24;
  localparam int unsigned ATTR_W         = 32;
  localparam int unsigned IDX_W          = PX_W + DIM_W + 1;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned DEF_MAX_WIDTH  = 512;
  localparam int unsigned DEF_MAX_HEIGHT = 512;

  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0]     DIM_RESET         = 10'd512;

  localparam logic ACT_TEST  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN     = 24'sh800000;
  localparam logic signed [DEPTH_W-1:0] DEPTH_POS_ONE = 24'sd4194304;
  localparam logic signed [DEPTH_W-1:0] DEPTH_NEG_ONE = -24'sd4194304;

  typedef struct packed {
    logic                      action;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [DEPTH_W-1:0] depth_value;
    logic [ATTR_W-1:0]         attr_a;
    logic [ATTR_W-1:0]         attr_b;
    logic [ATTR_W-1:0]         attr_c;
    logic [ATTR_W-1:0]         attr_d;
    logic [ATTR_W-1:0]         attr_e;
    logic [ATTR_W-1:0]         attr_f;
    logic [ATTR_W-1:0]         attr_g;
    logic [ATTR_W-1:0]         attr_h;
  } frag_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic [ATTR_W-1:0]         out_attr_a;
    logic [ATTR_W-1:0]         out_attr_b;
    logic [ATTR_W-1:0]         out_attr_c;
    logic [ATTR_W-1:0]         out_attr_d;
    logic [ATTR_W-1:0]         out_attr_e;
    logic [ATTR_W-1:0]         out_attr_f;
    logic [ATTR_W-1:0]         out_attr_g;
    logic [ATTR_W-1:0]         out_attr_h;
  } res_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_W-1:0]     wdata;
  } cfg_t;

  typedef struct packed {
    logic                      is_clear;
    logic signed [DEPTH_W-1:0] z;
    res_t                      res;
  } cmd_t;

  function automatic int unsigned addr_width(int unsigned size);
    return (size > 1) ? $clog2(size) : 1;
  endfunction

endpackage

// ===== src/dtfu_stream_if.sv =====
// valid/ready channel carrying one payload beat
interface dtfu_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/depth_test_fragment_unit_top.sv =====
// top level of the depth test fragment unit
//
// frag_i takes one beat per fragment or clear request, cfg_i writes buffer
// width (index 0) or height (index 1) and is always ready, res_o delivers one
// beat per fragment that passes the depth test.
// the front end drops fragments that are off screen or out of depth range in
// the cycle they are accepted; the rest go through a two-entry queue to the
// back end, which reads the depth memory, compares and writes back.
// a kept fragment occupies the back end for a read step, then a compare and
// write step on the single-port depth memory, so the back end takes no new
// fragment before the last is done; dropped fragments never reach it.
// a result passes through the queue, the read register and the output register.
// a clear request sweeps all MAX_WIDTH * MAX_HEIGHT entries (262144 by default)
// one entry per cycle; fragments keep queueing behind it.
// after reset the same sweep runs once and frag_i.ready stays low until it
// ends; config writes are taken throughout.
// a stalled res_o holds the result in the output register; a passing fragment
// then waits in the compare step and the queue fills before frag_i.ready drops.
module depth_test_fragment_unit_top #(
  parameter int unsigned MAX_WIDTH  = dtfu_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = dtfu_pkg::DEF_MAX_HEIGHT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dtfu_stream_if.sink   frag_i,
  dtfu_stream_if.sink   cfg_i,
  dtfu_stream_if.source res_o
);

  localparam int unsigned StoreSize = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW     = dtfu_pkg::addr_width(StoreSize);
  localparam int unsigned CmdW      = AddrW + $bits(dtfu_pkg::cmd_t);

  logic init_done;

  dtfu_stream_if #(.payload_t(logic [CmdW-1:0])) cmd_push ();
  dtfu_stream_if #(.payload_t(logic [CmdW-1:0])) cmd_pop ();

  dtfu_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_done_i (init_done),
    .frag_i      (frag_i),
    .cfg_i       (cfg_i),
    .cmd_o       (cmd_push)
  );

  dtfu_queue #(
    .DataW (CmdW),
    .Depth (dtfu_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_push),
    .out_o  (cmd_pop)
  );

  dtfu_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_pop),
    .res_o       (res_o),
    .init_done_o (init_done)
  );

endmodule

// ===== src/dtfu_front.sv =====
// front end: config registers, fragment classification and address calculation
module dtfu_front #(
  parameter int unsigned MAX_WIDTH  = dtfu_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = dtfu_pkg::DEF_MAX_HEIGHT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           init_done_i,
  dtfu_stream_if.sink    frag_i,
  dtfu_stream_if.sink    cfg_i,
  dtfu_stream_if.source  cmd_o
);

  localparam int unsigned StoreSize = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW     = dtfu_pkg::addr_width(StoreSize);
  localparam int unsigned DimW      = dtfu_pkg::DIM_W;
  localparam int unsigned PxW       = dtfu_pkg::PX_W;
  localparam int unsigned IdxW      = dtfu_pkg::IDX_W;
  localparam int unsigned CoordW    = dtfu_pkg::COORD_W;
  localparam int unsigned FracW     = dtfu_pkg::FRAC_W;

  logic [dtfu_pkg::CFG_W-1:0] width_q, height_q;
  dtfu_pkg::frag_t            frag;
  dtfu_pkg::cfg_t             cfg;
  dtfu_pkg::cmd_t             cmd;
  logic [DimW-1:0]            width_ext, height_ext, max_w, max_h, w_eff, h_eff;
  logic [PxW-1:0]             px, py;
  logic [IdxW-1:0]            idx;
  logic                       neg, in_bounds, z_ok, is_clear, keep;

  assign frag      = frag_i.data;
  assign cfg       = cfg_i.data;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dtfu_pkg::DIM_RESET;
      height_q <= dtfu_pkg::DIM_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg.reg_index)
        dtfu_pkg::REG_BUFFER_WIDTH:  width_q  <= cfg.wdata;
        dtfu_pkg::REG_BUFFER_HEIGHT: height_q <= cfg.wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    width_ext  = DimW'(width_q);
    height_ext = DimW'(height_q);
    max_w      = DimW'(MAX_WIDTH);
    max_h      = DimW'(MAX_HEIGHT);
    w_eff      = (width_ext > max_w) ? max_w : width_ext;
    h_eff      = (height_ext > max_h) ? max_h : height_ext;

    px        = frag.x_coord[CoordW-2:FracW];
    py        = frag.y_coord[CoordW-2:FracW];
    neg       = frag.x_coord[CoordW-1] | frag.y_coord[CoordW-1];
    in_bounds = (DimW'(px) < w_eff) && (DimW'(py) < h_eff);
    z_ok      = (frag.depth_value >= dtfu_pkg::DEPTH_NEG_ONE) &&
                (frag.depth_value <= dtfu_pkg::DEPTH_POS_ONE);
    idx       = IdxW'(py) * IdxW'(w_eff) + IdxW'(px);

    is_clear = (frag.action == dtfu_pkg::ACT_CLEAR);
    keep     = is_clear || (!neg && in_bounds && z_ok);

    cmd.is_clear       = is_clear;
    cmd.z              = frag.depth_value;
    cmd.res.out_x      = frag.x_coord;
    cmd.res.out_y      = frag.y_coord;
    cmd.res.out_attr_a = frag.attr_a;
    cmd.res.out_attr_b = frag.attr_b;
    cmd.res.out_attr_c = frag.attr_c;
    cmd.res.out_attr_d = frag.attr_d;
    cmd.res.out_attr_e = frag.attr_e;
    cmd.res.out_attr_f = frag.attr_f;
    cmd.res.out_attr_g = frag.attr_g;
    cmd.res.out_attr_h = frag.attr_h;
  end

  // dropped fragments are consumed here and never reach the queue
  assign cmd_o.data   = {idx[AddrW-1:0], cmd};
  assign cmd_o.valid  = frag_i.valid && init_done_i && keep;
  assign frag_i.ready = init_done_i && cmd_o.ready;

endmodule

// ===== src/dtfu_queue.sv =====
// short command queue between front and back end
module dtfu_queue #(
  parameter int unsigned DataW = 1,
  parameter int unsigned Depth = dtfu_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dtfu_stream_if.sink   in_i,
  dtfu_stream_if.source out_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign in_i.ready  = (cnt_q != CntW'(Depth));
  assign out_o.valid = (cnt_q != '0);
  assign out_o.data  = mem_q[rd_q];
  assign push        = in_i.valid && in_i.ready;
  assign pop         = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== src/dtfu_back.sv =====
// back end: depth memory, read-compare-write, clear sweep and output register
module dtfu_back #(
  parameter int unsigned MAX_WIDTH  = dtfu_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = dtfu_pkg::DEF_MAX_HEIGHT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dtfu_stream_if.sink   cmd_i,
  dtfu_stream_if.source res_o,
  output logic          init_done_o
);

  localparam int unsigned StoreSize = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW     = dtfu_pkg::addr_width(StoreSize);
  localparam int unsigned DepthW    = dtfu_pkg::DEPTH_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;

  logic signed [DepthW-1:0] mem [StoreSize];

  logic [1:0]               state_q, state_d;
  logic [AddrW-1:0]         clr_q, clr_d;
  logic                     init_done_q;
  logic [AddrW-1:0]         addr_q;
  dtfu_pkg::cmd_t           cur_q;
  logic signed [DepthW-1:0] rdata_q;
  logic                     out_valid_q;
  dtfu_pkg::res_t           out_q;

  logic [AddrW-1:0]         cmd_addr;
  dtfu_pkg::cmd_t           cmd_in;
  logic                     out_free, pass, clr_last, take;
  logic                     mem_we, mem_re, load_out;
  logic [AddrW-1:0]         mem_waddr;
  logic signed [DepthW-1:0] mem_wdata;

  assign {cmd_addr, cmd_in} = cmd_i.data;
  assign cmd_i.ready        = (state_q == ST_IDLE);
  assign take               = cmd_i.valid && cmd_i.ready;
  assign out_free           = !out_valid_q || res_o.ready;
  assign pass               = cur_q.z > rdata_q;
  assign clr_last           = (clr_q == AddrW'(StoreSize - 1));
  assign init_done_o        = init_done_q;
  assign res_o.valid        = out_valid_q;
  assign res_o.data         = out_q;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    load_out  = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = cur_q.z;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = dtfu_pkg::DEPTH_MIN;
        if (clr_last) begin
          clr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AddrW'(1);
        end
      end
      ST_IDLE: begin
        if (cmd_i.valid) begin
          if (cmd_in.is_clear) begin
            state_d = ST_CLEAR;
          end else begin
            mem_re  = 1'b1;
            state_d = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (!pass) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          mem_we   = 1'b1;
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[cmd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      addr_q <= cmd_addr;
      cur_q  <= cmd_in;
    end
    if (load_out) begin
      out_q <= cur_q.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      init_done_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (state_q == ST_CLEAR && clr_last) begin
        init_done_q <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
